/* rtl/kmi_pkg.sv */
// Package for the keyboard matrix interface: register offsets, masks,
// opcodes, queued command codes and the command word type.
// No dependencies.
package kmi_pkg;

    localparam logic [31:0] BLOCK_BASE    = 32'h0B00_0180;
    localparam logic [31:0] OFF_LAST_WORD = 32'h0000_000A;
    localparam logic [31:0] OFF_SCANREP   = 32'h0000_0010;
    localparam logic [31:0] OFF_SCANSTAT  = 32'h0000_0012;
    localparam logic [31:0] OFF_TIMING_A  = 32'h0000_0014;
    localparam logic [31:0] OFF_TIMING_B  = 32'h0000_0016;
    localparam logic [31:0] OFF_CAUSES    = 32'h0000_0018;
    localparam logic [31:0] OFF_TIMING_C  = 32'h0000_001C;
    localparam logic [31:0] OFF_TIMING_D  = 32'h0000_001E;

    localparam logic [15:0] SCANREP_MASK  = 16'h83FF;
    localparam int          SCAN_EN_BIT   = 15;
    localparam logic [2:0]  CAUSE_MASK    = 3'b111;
    localparam logic [2:0]  CAUSE_DATRDY  = 3'b010;

    localparam logic [7:0]  KEY_COUNT     = 8'd96;
    localparam int          MATRIX_WORDS  = 6;
    localparam int          WORD_W        = $clog2(MATRIX_WORDS);

    localparam logic [1:0]  OP_READ  = 2'd0;
    localparam logic [1:0]  OP_WRITE = 2'd1;
    localparam logic [1:0]  OP_KEY   = 2'd2;

    localparam logic [3:0]  CMD_ERR      = 4'd0;
    localparam logic [3:0]  CMD_RD_MAT   = 4'd1;
    localparam logic [3:0]  CMD_RD_SCAN  = 4'd2;
    localparam logic [3:0]  CMD_RD_STAT  = 4'd3;
    localparam logic [3:0]  CMD_RD_CAUSE = 4'd4;
    localparam logic [3:0]  CMD_WR_SCAN  = 4'd5;
    localparam logic [3:0]  CMD_WR_CAUSE = 4'd6;
    localparam logic [3:0]  CMD_WR_NOP   = 4'd7;
    localparam logic [3:0]  CMD_KEY      = 4'd8;

    typedef struct packed {
        logic [3:0]        kind;
        logic [15:0]       data;
        logic [WORD_W-1:0] word;
        logic [3:0]        bit_sel;
        logic              pressed;
    } t_cmd;

endpackage

/* rtl/kmi_front.sv */
// Front end: accepts input words, decodes address or key index into a
// queued command. Depends on kmi_pkg.
module kmi_front
    import kmi_pkg::*;
(
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_bus_address,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_key_index,
    input  logic        i_key_pressed,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [31:0] w_off;

    assign w_off      = i_bus_address - BLOCK_BASE;
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd         = '0;
        o_cmd.kind    = CMD_ERR;
        o_cmd.data    = i_write_data;
        o_cmd.pressed = i_key_pressed;
        o_cmd.bit_sel = i_key_index[3:0];
        unique case (i_opcode)
            OP_READ: begin
                o_cmd.word = w_off[WORD_W:1];
                if (w_off <= OFF_LAST_WORD && !w_off[0]) begin
                    o_cmd.kind = CMD_RD_MAT;
                end else begin
                    unique case (w_off) inside
                        OFF_SCANREP:  o_cmd.kind = CMD_RD_SCAN;
                        OFF_SCANSTAT: o_cmd.kind = CMD_RD_STAT;
                        OFF_CAUSES:   o_cmd.kind = CMD_RD_CAUSE;
                        default:      o_cmd.kind = CMD_ERR;
                    endcase
                end
            end
            OP_WRITE: begin
                unique case (w_off) inside
                    OFF_SCANREP: o_cmd.kind = CMD_WR_SCAN;
                    OFF_CAUSES:  o_cmd.kind = CMD_WR_CAUSE;
                    OFF_TIMING_A, OFF_TIMING_B, OFF_TIMING_C, OFF_TIMING_D:
                                 o_cmd.kind = CMD_WR_NOP;
                    default:     o_cmd.kind = CMD_ERR;
                endcase
            end
            OP_KEY: begin
                o_cmd.word = i_key_index[WORD_W+3:4];
                if (i_key_index < KEY_COUNT) begin
                    o_cmd.kind = CMD_KEY;
                end
            end
            default: o_cmd.kind = CMD_ERR;
        endcase
    end

endmodule

/* rtl/kmi_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on kmi_pkg.
module kmi_queue
    import kmi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");

endmodule

/* rtl/kmi_back.sv */
// Back end: executes queued commands against the key matrix, scan/repeat
// and cause registers; holds the result word. Depends on kmi_pkg.
module kmi_back
    import kmi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_data,
    output logic        o_access_error,
    output logic [2:0]  o_interrupt_causes
);

    logic [15:0] r_matrix [MATRIX_WORDS];
    logic [15:0] r_scan;
    logic [2:0]  r_causes;
    logic        r_out_valid;
    logic [15:0] r_rdata;
    logic        r_err;
    logic [2:0]  r_out_causes;

    logic [15:0] n_word;
    logic [15:0] n_scan;
    logic [2:0]  n_causes;
    logic [15:0] n_rdata;
    logic        n_err;
    logic        n_wr_word;
    logic        w_load;
    logic [15:0] w_cur;
    logic [15:0] w_mask;

    assign w_load = !r_out_valid || !i_out_stall;
    assign o_pop  = i_q_valid && w_load;
    assign w_cur  = r_matrix[i_cmd.word];
    assign w_mask = 16'd1 << i_cmd.bit_sel;

    always_comb begin
        n_word    = w_cur;
        n_scan    = r_scan;
        n_causes  = r_causes;
        n_rdata   = '0;
        n_err     = 1'b0;
        n_wr_word = 1'b0;
        unique case (i_cmd.kind)
            CMD_RD_MAT:   n_rdata = w_cur;
            CMD_RD_SCAN:  n_rdata = r_scan;
            CMD_RD_STAT:  n_rdata = {15'd0, r_scan[SCAN_EN_BIT]};
            CMD_RD_CAUSE: n_rdata = {13'd0, r_causes};
            CMD_WR_SCAN:  n_scan = i_cmd.data & SCANREP_MASK;
            CMD_WR_CAUSE: n_causes = r_causes & ~(i_cmd.data[2:0] & CAUSE_MASK);
            CMD_WR_NOP:   n_err = 1'b0;
            CMD_KEY: begin
                if (((w_cur & w_mask) != '0) != i_cmd.pressed) begin
                    n_wr_word = 1'b1;
                    n_word    = i_cmd.pressed ? (w_cur | w_mask) : (w_cur & ~w_mask);
                    if (r_scan[SCAN_EN_BIT]) begin
                        n_causes = r_causes | CAUSE_DATRDY;
                    end
                end
            end
            default: n_err = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MATRIX_WORDS; i++) begin
                r_matrix[i] <= '0;
            end
            r_scan      <= '0;
            r_causes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= i_q_valid;
            end
            if (o_pop) begin
                r_scan   <= n_scan;
                r_causes <= n_causes;
                if (n_wr_word) begin
                    r_matrix[i_cmd.word] <= n_word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata      <= n_rdata;
            r_err        <= n_err;
            r_out_causes <= n_causes;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_data        = r_rdata;
    assign o_access_error     = r_err;
    assign o_interrupt_causes = r_out_causes;

    a_only_datrdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_causes[0] && !r_causes[2]) else $error("unexpected cause bit set");
    a_scan_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan[14:10] == 5'd0) else $error("scan/repeat reserved bits set");
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_access_error) |-> o_read_data == 16'd0)
        else $error("error word carries read data");
    a_datrdy_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_causes[1]) |-> $past(o_pop && i_cmd.kind == CMD_KEY && r_scan[SCAN_EN_BIT]))
        else $error("data-ready set without key change");

endmodule

/* rtl/keyboard_matrix_interface_top.sv */
// Keyboard matrix interface top: front decode, two-entry queue, back end.
// Words are queued, then the back end registers each result; one word per cycle is
// taken unless the queue is full, one command retired a cycle unless output stalls.
// Reset: synchronous active low; clears matrix, scan/repeat, causes, queue.
// Depends on kmi_pkg, kmi_front, kmi_queue, kmi_back.
module keyboard_matrix_interface_top
    import kmi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_bus_address,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_key_index,
    input  logic        i_key_pressed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_data,
    output logic        o_access_error,
    output logic [2:0]  o_interrupt_causes
);

    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;

    kmi_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_bus_address (i_bus_address),
        .i_write_data  (i_write_data),
        .i_key_index   (i_key_index),
        .i_key_pressed (i_key_pressed),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    kmi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    kmi_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (w_q_valid),
        .i_cmd              (w_q_cmd),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_read_data        (o_read_data),
        .o_access_error     (o_access_error),
        .o_interrupt_causes (o_interrupt_causes)
    );

endmodule
